### rtl/rlb_pkg.sv
`default_nettype none

package rlb_pkg;

   // Blend mode codes held in the mode register.
   localparam logic [2:0] MODE_SUBTRACT = 3'd0;
   localparam logic [2:0] MODE_SCREEN   = 3'd1;
   localparam logic [2:0] MODE_OVERLAY  = 3'd2;
   localparam logic [2:0] MODE_SCALE    = 3'd3;
   localparam logic [2:0] MODE_ADD      = 3'd4;

   // Register indexes on the configuration port.
   localparam logic [1:0] CSR_BLEND_MODE    = 2'd0;
   localparam logic [1:0] CSR_RED_OPERAND   = 2'd1;
   localparam logic [1:0] CSR_GREEN_OPERAND = 2'd2;
   localparam logic [1:0] CSR_BLUE_OPERAND  = 2'd3;

   localparam logic [7:0] PIX_MAX = 8'd255;

   // One pixel pair presented on the request channel.
   typedef struct packed {
      logic [7:0] top_red;
      logic [7:0] top_green;
      logic [7:0] top_blue;
      logic [7:0] bottom_red;
      logic [7:0] bottom_green;
      logic [7:0] bottom_blue;
   } req_payload_type;

   // One blended pixel on the response channel.
   typedef struct packed {
      logic [7:0] out_red;
      logic [7:0] out_green;
      logic [7:0] out_blue;
   } rsp_payload_type;

   // Configuration state handed from the register file to the datapath.
   typedef struct packed {
      logic [2:0] blend_mode;
      logic [7:0] red_operand;
      logic [7:0] green_operand;
      logic [7:0] blue_operand;
   } cfg_type;

endpackage

`default_nettype wire

### rtl/rlb_div255.sv
`default_nettype none

module rlb_div255 (
   input  wire logic [15:0] dividend,
   output logic [7:0]       quotient
);
   import rlb_pkg::*;

   logic [15:0] approx_sum;
   logic [7:0]  estimate;
   logic [15:0] remainder;

   // Dividing by 256 and adding the 1/256 term lands on the true quotient
   // or one below it, for every dividend this datapath can produce.
   assign approx_sum = dividend + {8'd0, dividend[15:8]};
   assign estimate   = approx_sum[15:8];

   // One compare and subtract settles the last unit.
   assign remainder = dividend - ({8'd0, estimate} * 16'(PIX_MAX));
   assign quotient  = (remainder >= 16'(PIX_MAX)) ? estimate + 8'd1 : estimate;

endmodule

`default_nettype wire

### rtl/rlb_channel.sv
`default_nettype none

module rlb_channel (
   input  wire logic [2:0] blend_mode,
   input  wire logic [7:0] top_value,
   input  wire logic [7:0] bottom_value,
   input  wire logic [7:0] operand,
   output logic [7:0]      result
);
   import rlb_pkg::*;

   logic [7:0]  inv_top;
   logic [7:0]  inv_bottom;
   logic        overlay_low;
   logic [7:0]  mul_a;
   logic [7:0]  mul_b;
   logic [15:0] product;
   logic [15:0] scaled;
   logic [15:0] rounded;
   logic [7:0]  quotient;
   logic [8:0]  add_sum;

   assign inv_top     = PIX_MAX - top_value;
   assign inv_bottom  = PIX_MAX - bottom_value;
   assign overlay_low = ~bottom_value[7];

   // Pick the two factors of the single shared multiplier.
   always_comb begin
      unique case (blend_mode)
         MODE_SCREEN: begin
            mul_a = inv_top;
            mul_b = inv_bottom;
         end
         MODE_OVERLAY: begin
            mul_a = overlay_low ? top_value    : inv_top;
            mul_b = overlay_low ? bottom_value : inv_bottom;
         end
         MODE_SCALE: begin
            mul_a = bottom_value;
            mul_b = operand;
         end
         default: begin
            mul_a = inv_top;
            mul_b = inv_bottom;
         end
      endcase
   end

   assign product = 16'(mul_a) * 16'(mul_b);

   // Overlay doubles the product; one factor is then at most 127, so it fits.
   assign scaled  = (blend_mode == MODE_OVERLAY) ? {product[14:0], 1'b0} : product;
   assign rounded = scaled + 16'd127;

   rlb_div255 u_div255 (
      .dividend (rounded),
      .quotient (quotient)
   );

   assign add_sum = {1'b0, bottom_value} + {1'b0, operand};

   // Final selection per mode, with the clamps and saturations.
   always_comb begin
      unique case (blend_mode)
         MODE_SUBTRACT: result = (bottom_value > top_value) ? bottom_value - top_value : 8'd0;
         MODE_SCREEN:   result = PIX_MAX - quotient;
         MODE_OVERLAY:  result = overlay_low ? quotient : PIX_MAX - quotient;
         MODE_SCALE:    result = (product[15:8] != 8'd0) ? PIX_MAX : product[7:0];
         MODE_ADD:      result = add_sum[8] ? PIX_MAX : add_sum[7:0];
         default:       result = bottom_value;
      endcase
   end

endmodule

`default_nettype wire

### rtl/rlb_csr.sv
`default_nettype none

module rlb_csr (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_write,
   input  wire logic [1:0]  csr_index,
   input  wire logic [7:0]  csr_wdata,
   output rlb_pkg::cfg_type cfg
);
   import rlb_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Decode the register index of a write.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_BLEND_MODE:    cfg_in.blend_mode    = csr_wdata[2:0];
            CSR_RED_OPERAND:   cfg_in.red_operand   = csr_wdata;
            CSR_GREEN_OPERAND: cfg_in.green_operand = csr_wdata;
            CSR_BLUE_OPERAND:  cfg_in.blue_operand  = csr_wdata;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

### rtl/rgb_layer_blend_unit.sv
`default_nettype none
// Path: a pixel taken on the request channel waits in the input register, then its blend
// moves to the result register driving rsp_data. Throughput: one pixel per cycle while
// rsp_stall is low, through a single multiplier and divide-by-255 stage per channel.
// Reset: synchronous and active high; both pipeline stages empty, configuration reads zero.
// Configuration writes take effect on the following cycle.

module rgb_layer_blend_unit (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_stall,
   input  wire rlb_pkg::req_payload_type req_data,
   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   output rlb_pkg::rsp_payload_type     rsp_data,
   input  wire logic                    csr_write,
   input  wire logic [1:0]              csr_index,
   input  wire logic [7:0]              csr_wdata
);
   import rlb_pkg::*;

   cfg_type         cfg;
   logic            in_valid_ff;
   logic            in_valid_in;
   req_payload_type in_data_ff;
   logic            rsp_valid_ff;
   logic            rsp_valid_in;
   rsp_payload_type rsp_data_ff;
   rsp_payload_type blended;
   logic            load_in;
   logic            advance;

   rlb_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // The held pixel moves on whenever the result register is free or draining.
   assign advance   = in_valid_ff & (~rsp_valid_ff | ~rsp_stall);
   assign req_stall = in_valid_ff & rsp_valid_ff & rsp_stall;
   assign load_in   = req_valid & ~req_stall;

   assign in_valid_in  = load_in | (in_valid_ff & ~advance);
   assign rsp_valid_in = advance | (rsp_valid_ff & rsp_stall);

   // Three identical channel datapaths.
   rlb_channel u_red (
      .blend_mode   (cfg.blend_mode),
      .top_value    (in_data_ff.top_red),
      .bottom_value (in_data_ff.bottom_red),
      .operand      (cfg.red_operand),
      .result       (blended.out_red)
   );

   rlb_channel u_green (
      .blend_mode   (cfg.blend_mode),
      .top_value    (in_data_ff.top_green),
      .bottom_value (in_data_ff.bottom_green),
      .operand      (cfg.green_operand),
      .result       (blended.out_green)
   );

   rlb_channel u_blue (
      .blend_mode   (cfg.blend_mode),
      .top_value    (in_data_ff.top_blue),
      .bottom_value (in_data_ff.bottom_blue),
      .operand      (cfg.blue_operand),
      .result       (blended.out_blue)
   );

   // Pipeline control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers load on a transfer into their stage.
   always_ff @(posedge clock) begin
      if (load_in) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         rsp_data_ff <= blended;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // A pixel leaving the input stage is always waiting in the result register next.
   a_advance_fills: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("advanced pixel missing from result register");

   // Stalling upstream only when both stages are occupied.
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_valid_ff && rsp_valid_ff))
      else $error("request stalled with a free stage");

   // A held pixel keeps its value while it cannot move on.
   a_hold_input: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> (in_valid_ff && $stable(in_data_ff)))
      else $error("held input pixel lost or changed");

   // Every accepted transfer lands in the input stage.
   a_accept_lands: assert property (@(posedge clock) disable iff (reset)
      load_in |=> (in_valid_ff && (in_data_ff == $past(req_data))))
      else $error("accepted pixel not captured");

endmodule

`default_nettype wire

### tb/tb_rgb_layer_blend_unit.sv
module tb_rgb_layer_blend_unit;
   import rlb_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int HOLD_CYCLES    = 80;
   localparam int PHASE_COUNT    = 16;
   localparam int PHASE_PIXELS   = 75;

   logic            clock;
   logic            reset;
   logic            req_valid;
   logic            req_stall;
   req_payload_type req_data;
   logic            rsp_valid;
   logic            rsp_stall;
   rsp_payload_type rsp_data;
   logic            csr_write;
   logic [1:0]      csr_index;
   logic [7:0]      csr_wdata;

   // Shadow copy of the register file and the pixels still owed by the block.
   cfg_type         shadow_cfg;
   rsp_payload_type expected_pixels[$];
   rsp_payload_type want;
   int              error_count;
   int              quiet_cycles;

   // Flow control knobs shared between the stimulus and the receiver.
   bit              req_idle_on;
   bit              rsp_idle_on;
   bit              rsp_hold_req;
   int              hold_left;
   bit              cur_stall;
   int              run_left;

   rgb_layer_blend_unit u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // One colour channel of the blend, worked out in wide unsigned arithmetic.
   function automatic logic [7:0] mix_channel(input logic [2:0] mode, input logic [7:0] t,
                                              input logic [7:0] b, input logic [7:0] k);
      int unsigned full;
      int unsigned ti;
      int unsigned bi;
      int unsigned ki;
      int unsigned q;
      full = 32'(PIX_MAX);
      ti   = 32'(t);
      bi   = 32'(b);
      ki   = 32'(k);
      case (mode)
         MODE_SUBTRACT: q = (bi > ti) ? bi - ti : 0;
         MODE_SCREEN: begin
            q = ((full - ti) * (full - bi) + 127) / 255;
            q = (q > full) ? 0 : full - q;
         end
         MODE_OVERLAY: begin
            if (bi <= 127) begin
               q = (2 * ti * bi + 127) / 255;
            end else begin
               q = (2 * (full - ti) * (full - bi) + 127) / 255;
               q = (q > full) ? 0 : full - q;
            end
         end
         MODE_SCALE: q = bi * ki;
         MODE_ADD:   q = bi + ki;
         // Unused mode codes hand the bottom pixel straight through.
         default:    q = bi;
      endcase
      return (q > full) ? PIX_MAX : q[7:0];
   endfunction

   function automatic rsp_payload_type blend_pixel(input req_payload_type px);
      rsp_payload_type res;
      res.out_red   = mix_channel(shadow_cfg.blend_mode, px.top_red, px.bottom_red,
                                  shadow_cfg.red_operand);
      res.out_green = mix_channel(shadow_cfg.blend_mode, px.top_green, px.bottom_green,
                                  shadow_cfg.green_operand);
      res.out_blue  = mix_channel(shadow_cfg.blend_mode, px.top_blue, px.bottom_blue,
                                  shadow_cfg.blue_operand);
      return res;
   endfunction

   // Bottom values cluster around the overlay threshold now and then.
   function automatic logic [7:0] rand_bottom();
      if ($urandom_range(0, 3) == 0) begin
         return 8'($urandom_range(124, 131));
      end
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic req_payload_type random_pixel();
      req_payload_type px;
      px.top_red      = 8'($urandom_range(0, 255));
      px.top_green    = 8'($urandom_range(0, 255));
      px.top_blue     = 8'($urandom_range(0, 255));
      px.bottom_red   = rand_bottom();
      px.bottom_green = rand_bottom();
      px.bottom_blue  = rand_bottom();
      return px;
   endfunction

   function automatic logic [7:0] pick_operand();
      int unsigned r;
      r = $urandom_range(0, 5);
      case (r)
         0:       return 8'd0;
         1:       return 8'd255;
         2:       return 8'd1;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // Mostly short gaps between transfers, with the odd long one.
   function automatic int pick_gap();
      int unsigned r;
      if (!req_idle_on) begin
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 55) begin
         return 0;
      end
      if (r < 92) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 30);
   endfunction

   // Offer one pixel pair and record its blend once the transfer is taken.
   task automatic send_pixel(input req_payload_type px);
      int gap;
      gap = pick_gap();
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= px;
      do @(posedge clock); while (req_stall);
      expected_pixels.insert(expected_pixels.size(), blend_pixel(px));
   endtask

   // Stop sending and wait until every owed pixel has come back.
   task automatic drain_pixels();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      case (idx)
         CSR_BLEND_MODE:    shadow_cfg.blend_mode    = val[2:0];
         CSR_RED_OPERAND:   shadow_cfg.red_operand   = val;
         CSR_GREEN_OPERAND: shadow_cfg.green_operand = val;
         CSR_BLUE_OPERAND:  shadow_cfg.blue_operand  = val;
         default: ;
      endcase
      @(negedge clock);
      csr_write <= 1'b0;
   endtask

   // Straight after reset the block should subtract with zero operands.
   task automatic test_reset_defaults();
      send_pixel({8'd1, 8'd2, 8'd3, 8'd255, 8'd1, 8'd0});
      drain_pixels();
   endtask

   // Every mode code, unused ones included, against corner pixels and operand extremes.
   task automatic test_each_mode();
      logic [2:0] m;
      write_reg(CSR_RED_OPERAND, 8'd0);
      write_reg(CSR_GREEN_OPERAND, 8'd255);
      write_reg(CSR_BLUE_OPERAND, 8'd2);
      for (int i = 0; i < 8; i++) begin
         m = 3'(i);
         write_reg(CSR_BLEND_MODE, {5'(i * 7), m});
         send_pixel({8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255});
         send_pixel({8'd255, 8'd255, 8'd255, 8'd0, 8'd127, 8'd128});
         send_pixel({8'hAA, 8'h55, 8'h80, 8'h55, 8'hAA, 8'h7F});
         drain_pixels();
      end
   endtask

   // Random pixels over a series of register settings, idling switched per phase.
   task automatic test_random_blend();
      logic [2:0] m;
      for (int ph = 0; ph < PHASE_COUNT; ph++) begin
         req_idle_on = (ph % 4) != 3;
         rsp_idle_on = (ph % 4) != 1;
         m = (ph < 8) ? 3'(ph) : 3'($urandom_range(0, 7));
         write_reg(CSR_BLEND_MODE, {5'($urandom_range(0, 31)), m});
         if (ph == 0 || ph == 11) begin
            write_reg(CSR_RED_OPERAND, 8'd0);
            write_reg(CSR_GREEN_OPERAND, 8'd0);
            write_reg(CSR_BLUE_OPERAND, 8'd0);
         end else if (ph == 3 || ph == 12) begin
            write_reg(CSR_RED_OPERAND, 8'd255);
            write_reg(CSR_GREEN_OPERAND, 8'd255);
            write_reg(CSR_BLUE_OPERAND, 8'd255);
         end else begin
            write_reg(CSR_RED_OPERAND, pick_operand());
            write_reg(CSR_GREEN_OPERAND, pick_operand());
            write_reg(CSR_BLUE_OPERAND, pick_operand());
         end
         repeat (PHASE_PIXELS) send_pixel(random_pixel());
         drain_pixels();
      end
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
   endtask

   // The receiver holds off for a long stretch while pixels keep coming, so the
   // block fills and stalls its input; the sender then waits for the backlog.
   task automatic test_output_backpressure();
      req_idle_on  = 1'b0;
      rsp_hold_req = 1'b1;
      wait (hold_left > 0);
      repeat (20) send_pixel(random_pixel());
      drain_pixels();
      req_idle_on = 1'b1;
   endtask

   // Back-to-back transfers on both sides with no idling at all.
   task automatic test_full_rate();
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      write_reg(CSR_BLEND_MODE, {5'd0, MODE_OVERLAY});
      repeat (100) send_pixel(random_pixel());
      drain_pixels();
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
   endtask

   // Receiver: alternating runs of ready and stall, plus the long hold on request.
   initial begin
      rsp_stall = 1'b0;
      hold_left = 0;
      cur_stall = 1'b0;
      run_left  = 0;
      forever begin
         @(negedge clock);
         if (rsp_hold_req) begin
            rsp_hold_req = 1'b0;
            hold_left    = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left = hold_left - 1;
            rsp_stall <= 1'b1;
         end else if (!rsp_idle_on) begin
            rsp_stall <= 1'b0;
         end else if (run_left > 0) begin
            run_left = run_left - 1;
            rsp_stall <= cur_stall;
         end else begin
            cur_stall = ~cur_stall;
            if (!cur_stall) begin
               run_left = $urandom_range(0, 15);
            end else if ($urandom_range(0, 9) == 0) begin
               run_left = $urandom_range(12, 40);
            end else begin
               run_left = $urandom_range(0, 2);
            end
            rsp_stall <= cur_stall;
         end
      end
   end

   // Result check against the oldest owed pixel, and a watchdog on progress.
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles = 0;
      end else begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles = quiet_cycles + 1;
         end
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
         end else if (rsp_valid && !rsp_stall) begin
            if (expected_pixels.size() == 0) begin
               $error("unexpected result transfer: %h", rsp_data);
               error_count++;
            end else begin
               want = expected_pixels.pop_front();
               if (rsp_data.out_red !== want.out_red) begin
                  $error("out_red: expected %0d, got %0d", want.out_red, rsp_data.out_red);
                  error_count++;
               end
               if (rsp_data.out_green !== want.out_green) begin
                  $error("out_green: expected %0d, got %0d", want.out_green,
                         rsp_data.out_green);
                  error_count++;
               end
               if (rsp_data.out_blue !== want.out_blue) begin
                  $error("out_blue: expected %0d, got %0d", want.out_blue, rsp_data.out_blue);
                  error_count++;
               end
            end
         end
      end
   end

   initial begin
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_data     = '0;
      csr_write    = 1'b0;
      csr_index    = CSR_BLEND_MODE;
      csr_wdata    = '0;
      shadow_cfg   = '0;
      error_count  = 0;
      req_idle_on  = 1'b1;
      rsp_idle_on  = 1'b1;
      rsp_hold_req = 1'b0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_each_mode();
      test_random_blend();
      test_output_backpressure();
      test_full_rate();

      drain_pixels();
      repeat (4) @(posedge clock);
      if (error_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

### sim.f
rtl/rlb_pkg.sv
rtl/rlb_div255.sv
rtl/rlb_channel.sv
rtl/rlb_csr.sv
rtl/rgb_layer_blend_unit.sv
tb/tb_rgb_layer_blend_unit.sv
